// File: rtl/force_torque_calibration_defines.svh
`ifndef FORCE_TORQUE_CALIBRATION_DEFINES_SVH
`define FORCE_TORQUE_CALIBRATION_DEFINES_SVH

// checked at every clock edge outside reset
`define FTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define FTC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ftc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ftc_pkg;

	localparam int NUM_CH      = 6;
	localparam int GAUGE_W     = 16;
	localparam int DIFF_W      = GAUGE_W + 1;
	localparam int ROW_W       = 3;
	localparam int COEF_IN_W   = 24;
	localparam int COEF_MAX_W  = 32;
	localparam int OUT_W       = 32;
	localparam int VOLT_SHIFT  = 15;

	// input tdata layout, lowest bit first
	localparam int ZREQ_BIT    = NUM_CH * GAUGE_W;
	localparam int ROW_LSB     = ZREQ_BIT + 1;
	localparam int COL_LSB     = ROW_LSB + ROW_W;
	localparam int COEF_LSB    = COL_LSB + ROW_W;
	localparam int S_FIELD_W   = COEF_LSB + COEF_IN_W;
	localparam int S_TDATA_W   = ((S_FIELD_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = NUM_CH * OUT_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 2;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_CH - 1);
	localparam logic [ROW_W-1:0] NUM_ROWS = ROW_W'(NUM_CH);

	typedef enum logic {
		MODE_FRAME = 1'b0,
		MODE_LOAD  = 1'b1
	} ftc_mode_t;

	typedef struct packed {
		ftc_mode_t                        kind;
		logic                             latched;
		logic [ROW_W-1:0]                 row;
		logic [ROW_W-1:0]                 col;
		logic [COEF_IN_W-1:0]             coef;
		logic [NUM_CH-1:0][DIFF_W-1:0]    diff;
	} ftc_cmd_t;

	typedef struct packed {
		logic             v;
		logic [ROW_W-1:0] row;
		logic             latched;
	} ftc_tag_t;

	typedef struct packed {
		logic                          latched;
		logic [NUM_CH-1:0][OUT_W-1:0]  axis;
	} ftc_result_t;

endpackage
`default_nettype wire

// File: rtl/force_torque_calibration.sv
`timescale 1ns / 1ps
`default_nettype none
// Six-axis force/torque calibration: each sensor frame gives three forces and three torques
// in Q16.16, (gauge - offset) * 10/32768 times the 6x6 matrix, rounded to nearest and
// saturated. In the back end each frame goes one matrix row per cycle through six parallel
// multipliers; the next frame can start as the last row of the one before is read, unless
// two frames taken earlier still await their output transfer. A coefficient load gives no
// transfer on the output. The first frame after reset and any frame where zero_request
// rises capture their samples as the new offsets after computing with the old.
module force_torque_calibration import ftc_pkg::*; #(
	parameter int COEF_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// gauge0..gauge5, zero_request, coef_row, coef_col, coef_value, zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// mode
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// force_x, force_y, force_z, moment_x, moment_y, moment_z
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// offsets_latched
	output logic                 m_axis_tuser
);

	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;
	ftc_cmd_t q_cmd;
	ftc_cmd_t q_head;

	ftc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	ftc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	ftc_back #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// File: rtl/ftc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ftc_front import ftc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 q_full,
	output logic                 q_push,
	output ftc_cmd_t             q_cmd
);

	logic [NUM_CH-1:0][GAUGE_W-1:0] offset_q;
	logic                           prev_req_q;
	logic                           needs_zero_q;

	logic [NUM_CH-1:0][GAUGE_W-1:0] gauge;
	ftc_mode_t                      kind;
	logic                           zero_req;
	logic                           need;
	logic                           accept;
	logic                           in_range;

	assign gauge         = s_axis_tdata[NUM_CH*GAUGE_W-1:0];
	assign kind          = ftc_mode_t'(s_axis_tuser);
	assign zero_req      = s_axis_tdata[ZREQ_BIT];
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign need          = needs_zero_q || (zero_req && !prev_req_q);
	assign in_range      = (s_axis_tdata[ROW_LSB +: ROW_W] < NUM_ROWS) &&
	                       (s_axis_tdata[COL_LSB +: ROW_W] < NUM_ROWS);

	// loads outside the matrix are dropped here
	assign q_push = accept && ((kind == MODE_FRAME) || in_range);

	always_comb begin
		q_cmd.kind    = kind;
		q_cmd.latched = need;
		q_cmd.row     = s_axis_tdata[ROW_LSB +: ROW_W];
		q_cmd.col     = s_axis_tdata[COL_LSB +: ROW_W];
		q_cmd.coef    = s_axis_tdata[COEF_LSB +: COEF_IN_W];
		for (int i = 0; i < NUM_CH; i++) begin
			q_cmd.diff[i] = DIFF_W'($signed(gauge[i])) - DIFF_W'($signed(offset_q[i]));
		end
	end

	// results use the old offsets, the new ones apply from the next frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			prev_req_q   <= 1'b0;
			needs_zero_q <= 1'b1;
		end else if (accept && (kind == MODE_FRAME)) begin
			prev_req_q   <= zero_req;
			needs_zero_q <= 1'b0;
			if (need) begin
				offset_q <= gauge;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ftc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ftc_queue import ftc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ftc_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output ftc_cmd_t head
);

	ftc_cmd_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// File: rtl/ftc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ftc_back import ftc_pkg::*; #(
	parameter int COEF_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  ftc_cmd_t             q_head,
	output logic                 q_pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tuser
);

	localparam int PW = COEF_WIDTH + DIFF_W;
	localparam int SW = PW + 3;
	localparam int AW = (COEF_WIDTH + 24 > 48) ? COEF_WIDTH + 24 : 48;
	localparam int QW = AW - VOLT_SHIFT;

	// matrix storage, one row per word, valid bits stand for the zero reset
	logic [NUM_CH-1:0][COEF_WIDTH-1:0] mem_q [NUM_CH];
	logic [NUM_CH-1:0]                 vld_q [NUM_CH];

	logic                          active_q;
	logic [ROW_W-1:0]              row_q;
	logic [NUM_CH-1:0][DIFF_W-1:0] diff_q;
	logic                          latched_q;
	logic [1:0]                    pend_q;

	logic [NUM_CH-1:0][COEF_WIDTH-1:0] rd_s1;
	logic [NUM_CH-1:0]                 vld_s1;
	logic [NUM_CH-1:0][DIFF_W-1:0]     diff_s1;
	logic signed [PW-1:0]              prod_s2 [NUM_CH];
	logic signed [SW-1:0]              pair_s3 [NUM_CH/2];
	logic signed [SW-1:0]              sum_s4;
	logic signed [AW-1:0]              acc_s5;
	ftc_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic [NUM_CH-1:0][OUT_W-1:0] coll_q;
	ftc_result_t                  ofifo_q [OUT_DEPTH];
	logic [OPTR_W-1:0]            owr_q;
	logic [OPTR_W-1:0]            ord_q;
	logic [OCNT_W-1:0]            ocnt_q;

	logic                  slot_free;
	logic                  pop_frame;
	logic                  pop_load;
	logic [COEF_MAX_W-1:0] coef_ext;
	logic [COEF_WIDTH-1:0] coef_wr;
	logic [QW-1:0]         quot;
	logic [QW-OUT_W:0]     quot_hi;
	logic [OUT_W-1:0]      sat;
	logic                  opush;
	logic                  opop;
	ftc_result_t           ores;

	assign slot_free = !active_q || (row_q == LAST_ROW);
	assign pop_load  = !q_empty && (q_head.kind == MODE_LOAD) && slot_free;
	// a transfer in this cycle frees an output slot for the next frame
	assign pop_frame = !q_empty && (q_head.kind == MODE_FRAME) && slot_free &&
	                   ((pend_q != 2'd2) || opop);
	assign q_pop     = pop_load || pop_frame;

	assign coef_ext = COEF_MAX_W'(q_head.coef);
	assign coef_wr  = coef_ext[COEF_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (pop_load) begin
			mem_q[q_head.row][q_head.col] <= coef_wr;
		end
		rd_s1   <= mem_q[row_q];
		vld_s1  <= vld_q[row_q];
		diff_s1 <= diff_q;
		if (pop_frame) begin
			diff_q    <= q_head.diff;
			latched_q <= q_head.latched;
		end
	end

	// row sequencer: one matrix row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			row_q    <= '0;
			for (int r = 0; r < NUM_CH; r++) begin
				vld_q[r] <= '0;
			end
		end else begin
			if (pop_load) begin
				vld_q[q_head.row][q_head.col] <= 1'b1;
			end
			if (pop_frame) begin
				active_q <= 1'b1;
				row_q    <= '0;
			end else if (active_q && (row_q == LAST_ROW)) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// multiply, add pairs, add all, scale by ten with rounding
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			prod_s2[i] <= (vld_s1[i] ? PW'($signed(rd_s1[i])) : PW'(0)) *
			              PW'($signed(diff_s1[i]));
		end
		for (int j = 0; j < NUM_CH/2; j++) begin
			pair_s3[j] <= SW'(prod_s2[2*j]) + SW'(prod_s2[2*j+1]);
		end
		sum_s4 <= pair_s3[0] + pair_s3[1] + pair_s3[2];
		acc_s5 <= (AW'(sum_s4) <<< 3) + (AW'(sum_s4) <<< 1) +
		          (AW'(1) <<< (VOLT_SHIFT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= '{v: active_q, row: row_q, latched: latched_q};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// floor of the shifted sum, then clamp to 32 bits
	assign quot    = acc_s5[AW-1:VOLT_SHIFT];
	assign quot_hi = quot[QW-1:OUT_W-1];

	always_comb begin
		if ((&quot_hi) || !(|quot_hi)) begin
			sat = quot[OUT_W-1:0];
		end else if (quot[QW-1]) begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	assign opush = tag_s5.v && (tag_s5.row == LAST_ROW);
	assign opop  = m_axis_tvalid && m_axis_tready;

	always_comb begin
		ores.latched          = tag_s5.latched;
		ores.axis             = coll_q;
		ores.axis[LAST_ROW]   = sat;
	end

	always_ff @(posedge clk) begin
		if (tag_s5.v) begin
			coll_q[tag_s5.row] <= sat;
		end
		if (opush) begin
			ofifo_q[owr_q] <= ores;
		end
	end

	// pend_q counts frames taken from the queue whose result is not yet transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
			pend_q <= '0;
		end else begin
			if (opush) begin
				owr_q <= (owr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= (ord_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + OCNT_W'(opush) - OCNT_W'(opop);
			pend_q <= pend_q + 2'(pop_frame) - 2'(opop);
		end
	end

	assign m_axis_tvalid = (ocnt_q != '0);
	assign m_axis_tdata  = ofifo_q[ord_q].axis;
	assign m_axis_tuser  = ofifo_q[ord_q].latched;

endmodule
`default_nettype wire

// File: rtl/ftc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "force_torque_calibration_defines.svh"
module ftc_checker import ftc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 s_axis_tuser,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tuser
);

	logic [3:0] pend_q;
	logic       first_q;
	logic       s_frame;
	logic       m_xfer;

	assign s_frame = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_FRAME);
	assign m_xfer  = m_axis_tvalid && m_axis_tready;

	// frames accepted whose result is not yet out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			first_q <= 1'b1;
		end else begin
			pend_q <= pend_q + 4'(s_frame) - 4'(m_xfer);
			if (m_xfer) begin
				first_q <= 1'b0;
			end
		end
	end

	`FTC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
	`FTC_ASSERT(a_no_extra, m_xfer |-> pend_q != 4'd0, "result without a pending frame")
	`FTC_ASSERT(a_first_latch, m_xfer && first_q |-> m_axis_tuser, "first result after reset did not latch offsets")
	`FTC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind force_torque_calibration ftc_checker u_checker (.*);
`default_nettype wire
